@@ rtl/core/evp_pkg.sv @@
// shared constants and types for the exponent vector packer
`timescale 1ns / 1ps

package evp_pkg;

	// fixed port field widths
	localparam int SLOT_BITS       = 5;
	localparam int DEG_FIELD_BITS  = 16;
	localparam int WORD_FIELD_BITS = 64;
	localparam int S_TDATA_BITS    = 24;

	// per-transaction result limit and run counters
	localparam int MAX_RESULTS = 11;
	localparam int WC_BITS     = 4;
	localparam int WE_BITS     = 4;
	localparam logic [WE_BITS-1:0] WE_SAT = 4'd15;

	// opcodes carried on the input tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PACK = 1'b1;

	// parameter defaults
	localparam int NUM_SLOTS_DEF   = 32;
	localparam int WORD_BITS_DEF   = 64;
	localparam int DEGREE_BITS_DEF = 16;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DSET  = 8'b0000_0010,
		ST_DRUN  = 8'b0000_0100,
		ST_RD    = 8'b0000_1000,
		ST_PL    = 8'b0001_0000,
		ST_TAIL  = 8'b0010_0000,
		ST_PAD   = 8'b0100_0000,
		ST_FLUSH = 8'b1000_0000
	} evp_state_t;

endpackage

@@ rtl/core/exponent_vector_packer.sv @@
// exponent vector packer: slot width table, word count divider and field packer
`timescale 1ns / 1ps
// a last load then computes the word count by repeated subtraction, one subtract per
//   cycle on one subtractor (at most 11 steps)
// a pack walks each slot position with a table read, then a place (a slot past the table
//   takes the read only), then a flush; a last pack also passes the tail and padding
//   states, and every step that emits a word can be held by output stalls
// one transaction at a time; reset clears control and run state, the width table is unset

module exponent_vector_packer
	import evp_pkg::*;
#(
	parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
	parameter int WORD_BITS   = WORD_BITS_DEF,
	parameter int DEGREE_BITS = DEGREE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [S_TDATA_BITS-1:0]    s_axis_tdata,  // slot[4:0], degree[20:5], zero fill
	input  logic                       s_axis_tuser,  // opcode
	input  logic                       s_axis_tlast,  // last
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [WORD_FIELD_BITS-1:0] m_axis_tdata,  // packed_word[63:0]
	output logic                       m_axis_tuser,  // error
	output logic                       m_axis_tlast   // last_word
);

	// widest field a slot can get
	localparam int WMAXW     = (DEGREE_BITS < WORD_BITS) ? DEGREE_BITS : WORD_BITS;
	localparam int WID_BITS  = $clog2(WMAXW + 1);
	localparam int LEN_BITS  = $clog2(DEGREE_BITS + 1);
	localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);
	localparam int ADDR_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int TGT_BITS  = (CNT_BITS > SLOT_BITS) ? CNT_BITS : SLOT_BITS;
	localparam int BU_BITS   = $clog2(WORD_BITS + 1);
	localparam int SUM_BITS  = $clog2(NUM_SLOTS * WMAXW + 2);
	localparam int DIV_BITS  = (SUM_BITS > BU_BITS + 1) ? SUM_BITS : BU_BITS + 1;

	// input fields
	logic [SLOT_BITS-1:0]      in_slot;
	logic [DEG_FIELD_BITS-1:0] in_degree;
	logic [31:0]               in_deg32;
	logic [DEGREE_BITS-1:0]    in_deg;
	logic                      in_fire;

	assign in_slot   = s_axis_tdata[SLOT_BITS-1:0];
	assign in_degree = s_axis_tdata[SLOT_BITS +: DEG_FIELD_BITS];
	assign in_deg32  = 32'(in_degree);
	assign in_deg    = in_deg32[DEGREE_BITS-1:0];

	evp_state_t state_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// bit length of the incoming degree, priority encoder
	logic [5:0]          in_len;
	logic [LEN_BITS-1:0] in_len_n;
	logic [WID_BITS-1:0] in_width;

	always_comb begin
		in_len = '0;
		for (int i = 0; i < DEGREE_BITS; i++) begin
			if (in_deg[i]) begin
				in_len = 6'(i + 1);
			end
		end
		in_len_n = LEN_BITS'(in_len);
		if (32'(in_len) > 32'(WORD_BITS)) begin
			in_width = WID_BITS'(WORD_BITS);
		end else begin
			in_width = WID_BITS'(in_len);
		end
	end

	// slot table state
	logic [CNT_BITS-1:0] slot_count_q;
	logic [SUM_BITS-1:0] width_sum_q;
	logic [WID_BITS-1:0] width_max_q;
	logic [WC_BITS-1:0]  word_count_q;

	// load view after a restart on slot zero
	logic                restart;
	logic [CNT_BITS-1:0] ld_count;
	logic [SUM_BITS-1:0] ld_sum;
	logic [WID_BITS-1:0] ld_max;
	logic                ld_write;

	assign restart  = (in_slot == '0);
	assign ld_count = restart ? '0 : slot_count_q;
	assign ld_sum   = restart ? '0 : width_sum_q;
	assign ld_max   = restart ? '0 : width_max_q;
	assign ld_write = in_fire && (s_axis_tuser == OP_LOAD)
		&& (32'(ld_count) < 32'(NUM_SLOTS));

	// slot width and maximum table
	logic [WID_BITS-1:0]    width_mem [NUM_SLOTS];
	logic [DEGREE_BITS-1:0] max_mem   [NUM_SLOTS];
	logic [ADDR_BITS-1:0]   rd_addr;
	logic [WID_BITS-1:0]    rd_width_q;
	logic [DEGREE_BITS-1:0] rd_max_q;

	always_ff @(posedge clk) begin
		if (ld_write) begin
			width_mem[ld_count[ADDR_BITS-1:0]] <= in_width;
			max_mem[ld_count[ADDR_BITS-1:0]]   <= in_deg;
		end
		rd_width_q <= width_mem[rd_addr];
		rd_max_q   <= max_mem[rd_addr];
	end

	// pack run state
	logic [WORD_BITS-1:0]   acc_q;
	logic [BU_BITS-1:0]     bits_used_q;
	logic [WE_BITS-1:0]     words_emitted_q;
	logic                   error_seen_q;
	logic [CNT_BITS-1:0]    pos_q;
	logic [TGT_BITS-1:0]    target_q;
	logic [DEGREE_BITS-1:0] deg_q;
	logic [LEN_BITS-1:0]    deg_len_q;
	logic                   last_q;
	logic                   rd_tgt_q;
	logic [WC_BITS-1:0]     n_q;       // words produced in this transaction, capped

	// word count divider
	logic [DIV_BITS-1:0] rem_q;
	logic [WC_BITS-1:0]  wc_q;
	logic [DIV_BITS-1:0] div_q;

	assign div_q = DIV_BITS'(WORD_BITS) - DIV_BITS'(width_max_q) + DIV_BITS'(1);

	// pending word and output register
	logic [WORD_BITS-1:0] pend_q;
	logic                 pend_valid_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;
	logic                 out_last_q;
	logic                 out_err_q;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = WORD_FIELD_BITS'(out_word_q);
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_err_q;

	// position walk
	logic [TGT_BITS-1:0] pos_ext;
	logic [TGT_BITS-1:0] cnt_ext;
	logic [TGT_BITS-1:0] slot_ext;
	logic                zero_mode;
	logic                tgt_ok;

	assign pos_ext   = TGT_BITS'(pos_q);
	assign cnt_ext   = TGT_BITS'(slot_count_q);
	assign slot_ext  = TGT_BITS'(in_slot);
	assign zero_mode = (pos_ext < target_q) && (pos_ext < cnt_ext);
	assign tgt_ok    = (target_q < cnt_ext);
	assign rd_addr   = zero_mode ? pos_q[ADDR_BITS-1:0] : target_q[ADDR_BITS-1:0];

	// placement datapath, one shifter shared by every field
	logic                   out_free;
	logic                   can_emit;
	logic                   need_emit;
	logic [DEGREE_BITS-1:0] fmask;
	logic [WORD_BITS-1:0]   field_w;
	logic [BU_BITS-1:0]     bits_base;
	logic [WORD_BITS-1:0]   acc_base;
	logic [WORD_BITS-1:0]   acc_next;
	logic [BU_BITS-1:0]     bits_next;
	logic                   deg_bad;
	logic                   tail_need;
	logic                   pad_need;
	logic                   emit_fire;
	logic                   emit_keep;
	logic [WORD_BITS-1:0]   emit_word;
	logic                   flush_go;
	logic                   pend_to_out;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign can_emit  = (32'(n_q) >= MAX_RESULTS) || !pend_valid_q || out_free;
	assign need_emit = ((BU_BITS + 1)'(bits_used_q) + (BU_BITS + 1)'(rd_width_q))
		> (BU_BITS + 1)'(WORD_BITS);

	always_comb begin
		for (int i = 0; i < DEGREE_BITS; i++) begin
			fmask[i] = (i < 32'(rd_width_q));
		end
		field_w   = rd_tgt_q ? WORD_BITS'(32'(deg_q & fmask)) : '0;
		bits_base = need_emit ? '0 : bits_used_q;
		acc_base  = need_emit ? '0 : acc_q;
		acc_next  = acc_base | (field_w << bits_base);
		bits_next = bits_base + BU_BITS'(rd_width_q);
		deg_bad   = (deg_q > rd_max_q) || (32'(deg_len_q) > 32'(rd_width_q));
	end

	assign tail_need = (bits_used_q != '0) || (words_emitted_q == '0) || (n_q == '0);
	assign pad_need  = (words_emitted_q < word_count_q);

	// a word leaves the packer; beyond the per-transaction cap it is dropped
	assign emit_fire = can_emit && (((state_q == ST_PL) && need_emit)
		|| ((state_q == ST_TAIL) && tail_need)
		|| ((state_q == ST_PAD) && pad_need));
	assign emit_keep = emit_fire && (32'(n_q) < MAX_RESULTS);
	assign emit_word = (state_q == ST_PAD) ? '0 : acc_q;

	// the word still pending at the end of a transaction takes the last flag
	assign flush_go    = (state_q == ST_FLUSH) && (!pend_valid_q || out_free);
	assign pend_to_out = (emit_keep && pend_valid_q)
		|| ((state_q == ST_FLUSH) && pend_valid_q && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
			out_err_q    <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pend_to_out) begin
				out_valid_q <= 1'b1;
				out_last_q  <= (state_q == ST_FLUSH) && last_q;
				out_err_q   <= (state_q == ST_FLUSH) && last_q && error_seen_q;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_keep) begin
				pend_valid_q <= 1'b1;
			end else if (flush_go) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_to_out) begin
			out_word_q <= pend_q;
		end
		if (emit_keep) begin
			pend_q <= emit_word;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			slot_count_q    <= '0;
			width_sum_q     <= '0;
			width_max_q     <= '0;
			word_count_q    <= '0;
			acc_q           <= '0;
			bits_used_q     <= '0;
			words_emitted_q <= '0;
			error_seen_q    <= 1'b0;
			pos_q           <= '0;
			target_q        <= '0;
			deg_q           <= '0;
			deg_len_q       <= '0;
			last_q          <= 1'b0;
			rd_tgt_q        <= 1'b0;
			n_q             <= '0;
			rem_q           <= '0;
			wc_q            <= '0;
		end else begin
			if (emit_fire) begin
				if (words_emitted_q != WE_SAT) begin
					words_emitted_q <= words_emitted_q + 1'b1;
				end
				if (32'(n_q) < MAX_RESULTS) begin
					n_q <= n_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						last_q    <= s_axis_tlast;
						deg_q     <= in_deg;
						deg_len_q <= in_len_n;
						if (s_axis_tuser == OP_LOAD) begin
							slot_count_q <= ld_count;
							width_sum_q  <= ld_sum;
							width_max_q  <= ld_max;
							if (restart) begin
								word_count_q    <= '0;
								acc_q           <= '0;
								bits_used_q     <= '0;
								words_emitted_q <= '0;
								error_seen_q    <= 1'b0;
								pos_q           <= '0;
							end
							if (ld_write) begin
								slot_count_q <= ld_count + 1'b1;
								width_sum_q  <= ld_sum + SUM_BITS'(in_width);
								if (in_width > ld_max) begin
									width_max_q <= in_width;
								end
							end
							state_q <= s_axis_tlast ? ST_DSET : ST_IDLE;
						end else begin
							// a slot that goes back is taken as the current position
							target_q <= (slot_ext < pos_ext) ? pos_ext : slot_ext;
							n_q      <= '0;
							state_q  <= ST_RD;
						end
					end
				end
				ST_DSET: begin
					rem_q   <= DIV_BITS'(width_sum_q) - DIV_BITS'(width_max_q)
						+ DIV_BITS'(1);
					wc_q    <= '0;
					state_q <= ST_DRUN;
				end
				ST_DRUN: begin
					// ceiling division by repeated subtraction, capped at the result limit
					if ((rem_q != '0) && (32'(wc_q) < MAX_RESULTS)) begin
						rem_q <= (rem_q > div_q) ? (rem_q - div_q) : '0;
						wc_q  <= wc_q + 1'b1;
					end else begin
						word_count_q <= (slot_count_q == '0) ? '0 : wc_q;
						state_q      <= ST_IDLE;
					end
				end
				ST_RD: begin
					if (zero_mode) begin
						rd_tgt_q <= 1'b0;
						state_q  <= ST_PL;
					end else if (tgt_ok) begin
						rd_tgt_q <= 1'b1;
						state_q  <= ST_PL;
					end else begin
						// slot beyond the loaded table, degree dropped
						error_seen_q <= 1'b1;
						state_q      <= last_q ? ST_TAIL : ST_FLUSH;
					end
				end
				ST_PL: begin
					if (!need_emit || can_emit) begin
						acc_q       <= acc_next;
						bits_used_q <= bits_next;
						if (rd_tgt_q) begin
							if (deg_bad) begin
								error_seen_q <= 1'b1;
							end
							pos_q   <= CNT_BITS'(target_q + 1'b1);
							state_q <= last_q ? ST_TAIL : ST_FLUSH;
						end else begin
							pos_q   <= pos_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_TAIL: begin
					if (!tail_need || can_emit) begin
						state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					if (!pad_need) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (flush_go) begin
						if (last_q) begin
							acc_q           <= '0;
							bits_used_q     <= '0;
							words_emitted_q <= '0;
							error_seen_q    <= 1'b0;
							pos_q           <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/evp_word_checker.sv @@
// word checker: predicts the packed words of every transaction and compares them
`timescale 1ns / 1ps

module evp_word_checker
	import evp_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [S_TDATA_BITS-1:0]    s_axis_tdata,
	input  logic                       s_axis_tuser,
	input  logic                       s_axis_tlast,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [WORD_FIELD_BITS-1:0] m_axis_tdata,
	input  logic                       m_axis_tuser,
	input  logic                       m_axis_tlast,
	output int                         mismatches,
	output int                         words_pending
);

	typedef struct {
		logic [WORD_FIELD_BITS-1:0] word;
		logic                       last_word;
		logic                       error;
	} packed_word_t;

	packed_word_t expected_words[$];

	// slot table and word count of the loaded layout
	logic [6:0]                field_width [NUM_SLOTS_DEF];
	logic [DEG_FIELD_BITS-1:0] field_limit [NUM_SLOTS_DEF];
	logic [5:0]                slots_loaded;
	logic [9:0]                width_total;
	logic [6:0]                width_peak;
	logic [WC_BITS-1:0]        words_needed;

	// state of the pack run in progress
	logic [WORD_FIELD_BITS-1:0] word_acc;
	logic [6:0]                 acc_bits;
	logic [WE_BITS-1:0]         words_out;
	logic                       run_error;
	logic [5:0]                 next_pos;
	int                         step_count;

	function automatic int degree_len(logic [DEG_FIELD_BITS-1:0] d);
		int n;
		n = 0;
		for (int i = 0; i < DEG_FIELD_BITS; i++)
			if (d[i]) n = i + 1;
		return n;
	endfunction

	task automatic clear_run();
		word_acc  = '0;
		acc_bits  = '0;
		words_out = '0;
		run_error = 1'b0;
		next_pos  = '0;
	endtask

	// words past the per-transaction limit are dropped but still counted
	task automatic emit_word(logic [WORD_FIELD_BITS-1:0] w);
		if (step_count < MAX_RESULTS)
			expected_words.push_back('{w, 1'b0, 1'b0});
		step_count++;
		if (words_out != WE_SAT)
			words_out++;
	endtask

	task automatic place_field(int pos, logic [DEG_FIELD_BITS-1:0] d);
		int w;
		logic [WORD_FIELD_BITS-1:0] mask;
		w = field_width[pos];
		if (int'(acc_bits) + w > WORD_BITS_DEF) begin
			emit_word(word_acc);
			word_acc = '0;
			acc_bits = '0;
		end
		if (w > 0) begin
			mask = (w >= WORD_FIELD_BITS) ? '1 : ((64'd1 << w) - 64'd1);
			word_acc |= ({48'd0, d} & mask) << acc_bits;
			acc_bits += 7'(w);
		end
	endtask

	task automatic predict_words(logic op, logic [SLOT_BITS-1:0] slot,
			logic [DEG_FIELD_BITS-1:0] deg, logic last);
		int w;
		int target;
		int numer;
		int denom;
		int wc;
		step_count = 0;
		if (op == OP_LOAD) begin
			if (slot == 0) begin
				slots_loaded = '0;
				width_total  = '0;
				width_peak   = '0;
				words_needed = '0;
				clear_run();
			end
			if (slots_loaded < NUM_SLOTS_DEF) begin
				w = degree_len(deg);
				if (w > WORD_BITS_DEF) w = WORD_BITS_DEF;
				field_width[slots_loaded] = 7'(w);
				field_limit[slots_loaded] = deg;
				width_total += 10'(w);
				if (w > int'(width_peak)) width_peak = 7'(w);
				slots_loaded++;
			end
			if (last) begin
				if (slots_loaded == 0) begin
					words_needed = '0;
				end else begin
					numer = int'(width_total) - int'(width_peak) + 1;
					denom = WORD_BITS_DEF - int'(width_peak) + 1;
					wc = (numer + denom - 1) / denom;
					words_needed = (wc > MAX_RESULTS) ? WC_BITS'(MAX_RESULTS) : WC_BITS'(wc);
				end
			end
			return;
		end
		// skipped positions become zero fields, a slot going back means the current one
		target = (slot < next_pos) ? int'(next_pos) : int'(slot);
		while (next_pos < target && next_pos < slots_loaded) begin
			place_field(next_pos, '0);
			next_pos++;
		end
		if (target >= slots_loaded) begin
			run_error = 1'b1;
		end else begin
			if (deg > field_limit[target] || degree_len(deg) > field_width[target])
				run_error = 1'b1;
			place_field(target, deg);
			next_pos = 6'(target + 1);
		end
		if (last) begin
			if (acc_bits > 0 || words_out == 0 || step_count == 0)
				emit_word(word_acc);
			while (words_out < words_needed)
				emit_word('0);
			expected_words[expected_words.size()-1].last_word = 1'b1;
			expected_words[expected_words.size()-1].error     = run_error;
			clear_run();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		packed_word_t want;
		if (!arst_n) begin
			slots_loaded = '0;
			width_total  = '0;
			width_peak   = '0;
			words_needed = '0;
			for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
				field_width[i] = '0;
				field_limit[i] = '0;
			end
			clear_run();
			expected_words.delete();
			mismatches    = 0;
			words_pending = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_words(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[20:5],
					s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					$error("packed_word %h arrived with no word expected", m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (m_axis_tdata !== want.word) begin
						$error("packed_word: expected %h, actual %h", want.word, m_axis_tdata);
						mismatches++;
					end
					if (m_axis_tlast !== want.last_word) begin
						$error("last_word: expected %b, actual %b", want.last_word, m_axis_tlast);
						mismatches++;
					end
					if (m_axis_tuser !== want.error) begin
						$error("error: expected %b, actual %b", want.error, m_axis_tuser);
						mismatches++;
					end
				end
			end
			words_pending = expected_words.size();
		end
	end

endmodule

@@ tb/tb.sv @@
// testbench top: load and pack stimulus for the exponent vector packer and the verdict
`timescale 1ns / 1ps

module tb;
	import evp_pkg::*;

	logic                       clk;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [S_TDATA_BITS-1:0]    s_axis_tdata;   // slot[4:0], degree[20:5], zero fill
	logic                       s_axis_tuser;   // opcode
	logic                       s_axis_tlast;   // last
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [WORD_FIELD_BITS-1:0] m_axis_tdata;   // packed_word[63:0]
	logic                       m_axis_tuser;   // error
	logic                       m_axis_tlast;   // last_word

	int mismatches;
	int words_pending;
	int items_sent;
	logic steady_in;

	// stimulus-side view of the last well-formed load, used to shape pack degrees
	logic [DEG_FIELD_BITS-1:0] table_max [NUM_SLOTS_DEF];
	int                        table_slots;

	exponent_vector_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	evp_word_checker word_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.words_pending (words_pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// one input transaction: random gap first (none in steady stretches), then hold until taken
	task automatic send_item(logic op, logic [SLOT_BITS-1:0] slot,
			logic [DEG_FIELD_BITS-1:0] deg, logic last);
		int gap;
		if ($urandom_range(0, 15) == 0) steady_in = !steady_in;
		gap = steady_in ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, deg, slot};
		s_axis_tuser  <= op;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// well-formed load run: slots counted up from 0, runs past the table size go on with
	// nonzero slot fields so they are ignored rather than restarting
	task automatic load_table(int count);
		logic [DEG_FIELD_BITS-1:0] deg;
		int len;
		logic wide;
		wide = ($urandom_range(0, 2) == 0);
		for (int i = 0; i < count; i++) begin
			len = wide ? DEG_FIELD_BITS : $urandom_range(0, DEG_FIELD_BITS);
			deg = 16'($urandom) & 16'((32'd1 << len) - 1);
			if ($urandom_range(0, 3) == 0) deg = 16'((32'd1 << len) - 1);
			if (i < NUM_SLOTS_DEF) table_max[i] = deg;
			send_item(OP_LOAD, (i < NUM_SLOTS_DEF) ? 5'(i) : 5'($urandom_range(1, 31)), deg,
				i == count - 1);
		end
		table_slots = (count < NUM_SLOTS_DEF) ? count : NUM_SLOTS_DEF;
	endtask

	// pack run over a random ascending subset of the loaded slots; mostly legal degrees,
	// sometimes an out-of-range one, a slot past the table, or no closing last
	task automatic pack_term();
		int picks[$];
		int pos;
		logic [DEG_FIELD_BITS-1:0] deg;
		logic closed;
		for (pos = 0; pos < table_slots; pos++)
			if ($urandom_range(0, 4) != 0) picks.push_back(pos);
		if (table_slots < NUM_SLOTS_DEF && $urandom_range(0, 7) == 0)
			picks.push_back($urandom_range(table_slots, NUM_SLOTS_DEF - 1));
		if (picks.size() == 0) picks.push_back(0);
		closed = ($urandom_range(0, 9) != 0);
		foreach (picks[k]) begin
			pos = picks[k];
			if (pos >= table_slots || $urandom_range(0, 9) == 0)
				deg = 16'($urandom);
			else
				deg = 16'($urandom_range(0, table_max[pos]));
			send_item(OP_PACK, 5'(pos), deg, closed && k == picks.size() - 1);
		end
	endtask

	// output side: random stall before each word, with stretches of no stall
	initial begin
		int stall;
		logic steady_out;
		m_axis_tready = 1'b0;
		steady_out    = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 15) == 0) steady_out = !steady_out;
			stall = steady_out ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
			@(negedge clk);
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int random_start;
		int pick;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_LOAD;
		s_axis_tlast  = 1'b0;
		steady_in     = 1'b0;
		items_sent    = 0;
		table_slots   = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pack before any load: slot past the table, flagged error on a lone zero word
		send_item(OP_PACK, 5'd9, 16'hFFFF, 1'b1);

		// table of widths 0, 16, 1 and 9
		send_item(OP_LOAD, 5'd0, 16'd0, 1'b0);
		send_item(OP_LOAD, 5'd1, 16'hFFFF, 1'b0);
		send_item(OP_LOAD, 5'd2, 16'd1, 1'b0);
		send_item(OP_LOAD, 5'd3, 16'd300, 1'b1);

		// skipped slots, degree above its maximum, slot going back past the table
		send_item(OP_PACK, 5'd1, 16'hFFFF, 1'b0);
		send_item(OP_PACK, 5'd3, 16'd400, 1'b0);
		send_item(OP_PACK, 5'd2, 16'd5, 1'b1);

		// clean term that only touches a zero-width field
		send_item(OP_PACK, 5'd0, 16'd0, 1'b1);

		// pack run aborted by a load restart; nonzero load slots only append
		send_item(OP_PACK, 5'd3, 16'd511, 1'b0);
		send_item(OP_LOAD, 5'd0, 16'hFFFF, 1'b0);
		send_item(OP_LOAD, 5'd7, 16'hFFFF, 1'b0);
		send_item(OP_LOAD, 5'd9, 16'hFFFF, 1'b0);
		send_item(OP_LOAD, 5'd31, 16'hFFFF, 1'b0);
		send_item(OP_LOAD, 5'd4, 16'hFFFF, 1'b1);

		// five 16-bit fields: word boundary after the fourth, zero fields for skipped slots
		send_item(OP_PACK, 5'd4, 16'hFFFF, 1'b1);
		for (int i = 0; i < 5; i++)
			send_item(OP_PACK, 5'(i), 16'hFFFF, i == 4);

		// short term padded up to the word count
		send_item(OP_PACK, 5'd0, 16'd7, 1'b1);

		// single one-bit slot
		send_item(OP_LOAD, 5'd0, 16'd1, 1'b1);
		send_item(OP_PACK, 5'd0, 16'd1, 1'b1);

		// random part: mostly pack runs over random tables, some reloads and some noise
		random_start = items_sent;
		load_table($urandom_range(1, 8));
		while (items_sent - random_start < 160) begin
			pick = $urandom_range(0, 19);
			if (pick < 3) begin
				if ($urandom_range(0, 5) == 0)
					load_table($urandom_range(9, 34));
				else
					load_table($urandom_range(1, 8));
			end else if (pick < 17) begin
				pack_term();
			end else begin
				send_item(1'($urandom), 5'($urandom), 16'($urandom), 1'($urandom));
			end
		end
		s_axis_tvalid <= 1'b0;

		// drain, then leave room for a late word count or stray output
		wait (words_pending == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && words_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/evp_pkg.sv
rtl/core/exponent_vector_packer.sv
tb/evp_word_checker.sv
tb/tb.sv
